>>> hw/rtl/ipv4_receive_header_checker_assert.svh
// Assertion macros for the IPv4 receive header checker.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef IPV4_RECEIVE_HEADER_CHECKER_ASSERT_SVH
`define IPV4_RECEIVE_HEADER_CHECKER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted
`define IPV4RX_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define IPV4RX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define IPV4RX_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define IPV4RX_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/ipv4rx_pkg.sv
// Shared types and constants for the IPv4 receive header checker.
// No dependencies; used by the capture unit and the top level.
package ipv4rx_pkg;

  // Protocol slot table
  localparam int PROTO_SLOT_MAX   = 4;
  localparam int PROTO_SLOT_COUNT = 4;

  // Header layout and checks
  localparam logic [15:0] HDR_MIN        = 16'd20;
  localparam logic [3:0]  IPV4_VERSION   = 4'd4;
  localparam logic [15:0] FRAG_MF_MASK   = 16'h2000;
  localparam logic [15:0] FRAG_OFS_MASK  = 16'h1fff;
  localparam logic [15:0] SUM_GOOD       = 16'hffff;
  localparam logic [15:0] COUNT_MAX      = 16'hffff;
  localparam logic [31:0] LIMITED_BCAST  = 32'hffffffff;

  // Header byte positions
  localparam logic [4:0] POS_VER_IHL  = 5'd0;
  localparam logic [4:0] POS_TOTAL_HI = 5'd2;
  localparam logic [4:0] POS_TOTAL_LO = 5'd3;
  localparam logic [4:0] POS_FRAG_HI  = 5'd6;
  localparam logic [4:0] POS_FRAG_LO  = 5'd7;
  localparam logic [4:0] POS_PROTO    = 5'd9;
  localparam logic [4:0] POS_SRC0     = 5'd12;
  localparam logic [4:0] POS_SRC1     = 5'd13;
  localparam logic [4:0] POS_SRC2     = 5'd14;
  localparam logic [4:0] POS_SRC3     = 5'd15;
  localparam logic [4:0] POS_DST0     = 5'd16;
  localparam logic [4:0] POS_DST1     = 5'd17;
  localparam logic [4:0] POS_DST2     = 5'd18;
  localparam logic [4:0] POS_DST3     = 5'd19;

  // Configuration port
  localparam int CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_IFACE_PRESENT = 3'd0,
    REG_IFACE_ADDRESS = 3'd1,
    REG_IFACE_NETMASK = 3'd2,
    REG_PROTO_SLOT_A  = 3'd3,
    REG_PROTO_SLOT_B  = 3'd4,
    REG_PROTO_SLOT_C  = 3'd5,
    REG_PROTO_SLOT_D  = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    V_DELIVER     = 4'd0,
    V_SHORT       = 4'd1,
    V_VERSION     = 4'd2,
    V_HLEN        = 4'd3,
    V_TOTAL       = 4'd4,
    V_CHECKSUM    = 4'd5,
    V_FRAGMENT    = 4'd6,
    V_NO_IFACE    = 4'd7,
    V_NOT_OURS    = 4'd8,
    V_UNSUPPORTED = 4'd9
  } verdict_t;

  // Header fields as they stand after the current byte
  typedef struct packed {
    logic [15:0] len;
    logic [7:0]  version_ihl;
    logic [5:0]  hlen;
    logic [15:0] total;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sum;
    logic        at_start;
  } hdr_view_t;

endpackage

>>> hw/rtl/ipv4rx_channels.sv
// Handshake channels for the IPv4 receive header checker: packet bytes in,
// verdict words out. Depends on nothing but plain logic types.
interface ipv4rx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       pkt_last;

  modport source (output valid, output pkt_byte, output pkt_last, input ready);
  modport sink   (input valid, input pkt_byte, input pkt_last, output ready);
endinterface

interface ipv4rx_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [7:0]  proto_number;
  logic [5:0]  header_bytes;
  logic [15:0] payload_len;
  logic [31:0] src_address;
  logic [31:0] dst_address;

  modport source (output valid, output verdict, output proto_number, output header_bytes,
                  output payload_len, output src_address, output dst_address,
                  input ready);
  modport sink   (input valid, input verdict, input proto_number, input header_bytes,
                  input payload_len, input src_address, input dst_address,
                  output ready);
endinterface

>>> hw/rtl/ipv4rx_capture.sv
// Per-packet header capture and running ones' complement checksum.
// Uses ipv4rx_pkg for byte positions and the header view struct.
module ipv4rx_capture (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            pkt_byte,
  input  logic                  pkt_last,
  output ipv4rx_pkg::hdr_view_t view
);

  logic [15:0] cnt_r,   cnt_nxt;
  logic [15:0] sum_r,   sum_nxt;
  logic [7:0]  hold_r,  hold_nxt;
  logic [7:0]  vi_r,    vi_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] frag_r,  frag_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r,   src_nxt;
  logic [31:0] dst_r,   dst_nxt;
  logic [5:0]  hlen;
  logic [16:0] sum_wide;

  // Field capture for the header byte at the current position
  always_comb begin
    vi_nxt    = (cnt_r == 16'd0) ? pkt_byte : vi_r;
    total_nxt = total_r;
    frag_nxt  = frag_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    if (cnt_r < ipv4rx_pkg::HDR_MIN) begin
      unique case (cnt_r[4:0])
        ipv4rx_pkg::POS_TOTAL_HI: total_nxt[15:8] = pkt_byte;
        ipv4rx_pkg::POS_TOTAL_LO: total_nxt[7:0]  = pkt_byte;
        ipv4rx_pkg::POS_FRAG_HI:  frag_nxt[15:8]  = pkt_byte;
        ipv4rx_pkg::POS_FRAG_LO:  frag_nxt[7:0]   = pkt_byte;
        ipv4rx_pkg::POS_PROTO:    proto_nxt       = pkt_byte;
        ipv4rx_pkg::POS_SRC0:     src_nxt[31:24]  = pkt_byte;
        ipv4rx_pkg::POS_SRC1:     src_nxt[23:16]  = pkt_byte;
        ipv4rx_pkg::POS_SRC2:     src_nxt[15:8]   = pkt_byte;
        ipv4rx_pkg::POS_SRC3:     src_nxt[7:0]    = pkt_byte;
        ipv4rx_pkg::POS_DST0:     dst_nxt[31:24]  = pkt_byte;
        ipv4rx_pkg::POS_DST1:     dst_nxt[23:16]  = pkt_byte;
        ipv4rx_pkg::POS_DST2:     dst_nxt[15:8]   = pkt_byte;
        ipv4rx_pkg::POS_DST3:     dst_nxt[7:0]    = pkt_byte;
        default: ;
      endcase
    end
  end

  // Header length follows the version/IHL byte, including the one arriving now
  assign hlen = {vi_nxt[3:0], 2'b00};

  // Checksum: hold the even byte, add the word on the odd byte, fold the carry
  assign sum_wide = {1'b0, sum_r} + {1'b0, hold_r, pkt_byte};

  always_comb begin
    hold_nxt = hold_r;
    sum_nxt  = sum_r;
    if (cnt_r < {10'd0, hlen}) begin
      if (!cnt_r[0]) begin
        hold_nxt = pkt_byte;
      end else begin
        sum_nxt = sum_wide[15:0] + {15'd0, sum_wide[16]};
      end
    end
  end

  // Saturating byte count
  assign cnt_nxt = (cnt_r != ipv4rx_pkg::COUNT_MAX) ? cnt_r + 16'd1 : ipv4rx_pkg::COUNT_MAX;

  // Advance on each byte, clear everything after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      vi_r    <= '0;
      total_r <= '0;
      frag_r  <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
    end else if (step) begin
      if (pkt_last) begin
        cnt_r   <= '0;
        sum_r   <= '0;
        hold_r  <= '0;
        vi_r    <= '0;
        total_r <= '0;
        frag_r  <= '0;
        proto_r <= '0;
        src_r   <= '0;
        dst_r   <= '0;
      end else begin
        cnt_r   <= cnt_nxt;
        sum_r   <= sum_nxt;
        hold_r  <= hold_nxt;
        vi_r    <= vi_nxt;
        total_r <= total_nxt;
        frag_r  <= frag_nxt;
        proto_r <= proto_nxt;
        src_r   <= src_nxt;
        dst_r   <= dst_nxt;
      end
    end
  end

  // Fields as they stand once the current byte is in
  always_comb begin
    view.len         = cnt_nxt;
    view.version_ihl = vi_nxt;
    view.hlen        = hlen;
    view.total       = total_nxt;
    view.frag        = frag_nxt;
    view.proto       = proto_nxt;
    view.src         = src_nxt;
    view.dst         = dst_nxt;
    view.sum         = sum_nxt;
    view.at_start    = (cnt_r == 16'd0);
  end

endmodule

>>> hw/rtl/ipv4_receive_header_checker.sv
// IPv4 receive header checker: one packet byte per word, one verdict per packet.
// The last byte passes through the byte input register, then loads the verdict register.
// Throughput: 1 byte per cycle; the byte input register and the verdict register
// part the two sides, so input stalls only while a last byte waits on a full output.
// Reset (rst_n low, synchronous) clears the configuration registers, capture state and both valids.
// Depends on ipv4rx_pkg, ipv4rx_channels, ipv4rx_capture and the assertion header.
`include "ipv4_receive_header_checker_assert.svh"

module ipv4_receive_header_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  ipv4rx_in_if.sink                         in_ch,
  ipv4rx_out_if.source                      out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ipv4rx_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  // Configuration registers
  logic        iface_present_r;
  logic [31:0] iface_address_r;
  logic [31:0] iface_netmask_r;
  logic [8:0]  proto_slot_r [ipv4rx_pkg::PROTO_SLOT_MAX];

  // Input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  // Verdict register
  logic        out_valid_r;
  logic [3:0]  verdict_r;
  logic [7:0]  proto_r;
  logic [5:0]  hbytes_r;
  logic [15:0] payload_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;

  logic                  out_free;
  logic                  advance;
  logic                  cfg_wr;
  ipv4rx_pkg::reg_idx_t  cfg_idx;
  ipv4rx_pkg::hdr_view_t view;
  ipv4rx_pkg::verdict_t  verdict;
  logic [15:0]           payload;
  logic [31:0]           bcast;
  logic                  proto_hit;
  logic [15:0]           hlen16;

  // Configuration write and read-back
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = ipv4rx_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iface_present_r <= 1'b0;
      iface_address_r <= '0;
      iface_netmask_r <= '0;
      for (int k = 0; k < ipv4rx_pkg::PROTO_SLOT_MAX; k++) begin
        proto_slot_r[k] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ipv4rx_pkg::REG_IFACE_PRESENT: iface_present_r <= cfg_pwdata[0];
        ipv4rx_pkg::REG_IFACE_ADDRESS: iface_address_r <= cfg_pwdata;
        ipv4rx_pkg::REG_IFACE_NETMASK: iface_netmask_r <= cfg_pwdata;
        ipv4rx_pkg::REG_PROTO_SLOT_A:  proto_slot_r[0] <= cfg_pwdata[8:0];
        ipv4rx_pkg::REG_PROTO_SLOT_B:  proto_slot_r[1] <= cfg_pwdata[8:0];
        ipv4rx_pkg::REG_PROTO_SLOT_C:  proto_slot_r[2] <= cfg_pwdata[8:0];
        ipv4rx_pkg::REG_PROTO_SLOT_D:  proto_slot_r[3] <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ipv4rx_pkg::REG_IFACE_PRESENT: cfg_prdata = {31'd0, iface_present_r};
      ipv4rx_pkg::REG_IFACE_ADDRESS: cfg_prdata = iface_address_r;
      ipv4rx_pkg::REG_IFACE_NETMASK: cfg_prdata = iface_netmask_r;
      ipv4rx_pkg::REG_PROTO_SLOT_A:  cfg_prdata = {23'd0, proto_slot_r[0]};
      ipv4rx_pkg::REG_PROTO_SLOT_B:  cfg_prdata = {23'd0, proto_slot_r[1]};
      ipv4rx_pkg::REG_PROTO_SLOT_C:  cfg_prdata = {23'd0, proto_slot_r[2]};
      ipv4rx_pkg::REG_PROTO_SLOT_D:  cfg_prdata = {23'd0, proto_slot_r[3]};
      default:                       cfg_prdata = '0;
    endcase
  end

  // Handshake: a non-last byte always moves on; a last byte needs a free output slot
  assign out_free     = !out_valid_r || out_ch.ready;
  assign advance      = in_valid_r && (!in_last_r || out_free);
  assign in_ch.ready  = !in_valid_r || advance;

  // Hold the accepted word until the capture stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.pkt_byte;
      in_last_r <= in_ch.pkt_last;
    end
  end

  ipv4rx_capture u_capture (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .pkt_byte (in_byte_r),
    .pkt_last (in_last_r),
    .view     (view)
  );

  // Directed broadcast and protocol table lookup
  assign bcast  = (iface_address_r & iface_netmask_r) | ~iface_netmask_r;
  assign hlen16 = {10'd0, view.hlen};

  always_comb begin
    proto_hit = 1'b0;
    for (int k = 0; k < ipv4rx_pkg::PROTO_SLOT_COUNT; k++) begin
      if (proto_slot_r[k][8] && (proto_slot_r[k][7:0] == view.proto)) begin
        proto_hit = 1'b1;
      end
    end
  end

  // Verdict in check order
  always_comb begin
    payload = '0;
    priority if (view.len < ipv4rx_pkg::HDR_MIN) begin
      verdict = ipv4rx_pkg::V_SHORT;
    end else if (view.version_ihl[7:4] != ipv4rx_pkg::IPV4_VERSION) begin
      verdict = ipv4rx_pkg::V_VERSION;
    end else if (view.len < hlen16) begin
      verdict = ipv4rx_pkg::V_HLEN;
    end else if ((view.len < view.total) || (view.total < hlen16)) begin
      verdict = ipv4rx_pkg::V_TOTAL;
    end else if (view.sum != ipv4rx_pkg::SUM_GOOD) begin
      verdict = ipv4rx_pkg::V_CHECKSUM;
    end else if ((view.frag & (ipv4rx_pkg::FRAG_MF_MASK | ipv4rx_pkg::FRAG_OFS_MASK)) != '0)
    begin
      verdict = ipv4rx_pkg::V_FRAGMENT;
    end else if (!iface_present_r) begin
      verdict = ipv4rx_pkg::V_NO_IFACE;
    end else if ((view.dst != iface_address_r) && (view.dst != bcast) &&
                 (view.dst != ipv4rx_pkg::LIMITED_BCAST)) begin
      verdict = ipv4rx_pkg::V_NOT_OURS;
    end else if (!proto_hit) begin
      verdict = ipv4rx_pkg::V_UNSUPPORTED;
    end else begin
      verdict = ipv4rx_pkg::V_DELIVER;
      payload = view.total - hlen16;
    end
  end

  // Load the verdict word on the last byte, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      verdict_r <= verdict;
      proto_r   <= view.proto;
      hbytes_r  <= view.hlen;
      payload_r <= payload;
      src_r     <= view.src;
      dst_r     <= view.dst;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.verdict      = verdict_r;
  assign out_ch.proto_number = proto_r;
  assign out_ch.header_bytes = hbytes_r;
  assign out_ch.payload_len  = payload_r;
  assign out_ch.src_address  = src_r;
  assign out_ch.dst_address  = dst_r;

  // Input stalls only behind a last byte that waits on a full output
  `IPV4RX_ASSERT_SAME(a_stall_cause, clk, rst_n, !in_ch.ready,
    in_valid_r && in_last_r && out_valid_r && !out_ch.ready)

  // Capture state starts over after every last byte
  `IPV4RX_ASSERT_NEXT(a_clear_after_last, clk, rst_n, advance && in_last_r, view.at_start)

  // A byte that is not last leaves the packet open
  `IPV4RX_ASSERT_NEXT(a_count_runs, clk, rst_n, advance && !in_last_r, !view.at_start)

  // Payload length is only reported on delivery
  `IPV4RX_ASSERT_SAME(a_payload_deliver, clk, rst_n,
    out_valid_r && (verdict_r != ipv4rx_pkg::V_DELIVER), payload_r == 16'd0)

endmodule
